### design/ckerng_pkg.sv
package ckerng_pkg;

   // word and field widths
   localparam int WORD_W      = 32;
   localparam int REG_W       = 64;
   localparam int ROUND_W     = 5;
   localparam int COUNT_W     = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 136;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] REG_ROUND_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_KEY_A  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_KEY_B  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_KEY_C  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_KEY_D  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED_NONCE  = 3'd5;

   // request kinds carried on req_tuser
   localparam logic REQ_RESEED   = 1'b0;
   localparam logic REQ_GENERATE = 1'b1;

   localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 5'd20;
   localparam logic [COUNT_W-1:0] MAX_BYTES         = 5'd16;

   // "expand 32-byte k"
   localparam logic [WORD_W-1:0] EXPAND_WORDS [4] = '{
      32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
   };

   typedef logic [WORD_W-1:0] word_type;

endpackage

### design/chacha_key_erasure_rng.sv
// chacha_key_erasure_rng: chacha random generator with fast key erasure
//
// req channel: req_tuser selects the request kind (reseed or generate),
// req_tdata[4:0] holds the byte count of a generate request. a reseed copies
// the seed key and nonce registers into the working key in the transfer
// cycle itself and produces no result. a generate with a zero byte count is
// dropped. any other generate runs ceil(round_count/2) double rounds and the
// feed-forward, returns words 10..13 on rsp and replaces key and nonce with
// words 0..9 of the block.
//
// one quarter-round step (add, xor, rotate) per cycle in four lanes; a double
// round is eight steps. req_tready is low for the whole run of a generate
// and comes back with rsp_tvalid; a reseed leaves req_tready high.
// rsp is held in an output register, so a new request is taken while a result
// waits; a finished block waits in the feed-forward step while rsp stalls.
// reset (synchronous) clears the key, nonce and seed registers, sets
// round_count to 20 and empties the output register.
module chacha_key_erasure_rng
   import ckerng_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [4:0] byte_count, rest zero
   input  logic                   req_tuser,   // [0] req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [63:0] random_lo, [127:64] random_hi,
                                               // [132:128] valid_bytes, rest zero
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_wdata
);

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FEED = 2'd2;

   // configuration registers
   logic [ROUND_W-1:0] round_count_ff;
   logic [REG_W-1:0]   seed_key_ff [4];
   logic [REG_W-1:0]   seed_nonce_ff;

   // generator state
   word_type key_ff [8];
   word_type key_in [8];
   word_type nonce_ff [2];
   word_type nonce_in [2];

   // working block and sequencer
   word_type           w_ff [16];
   word_type           w_in [16];
   logic [1:0]         state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   logic               diag_ff, diag_in;
   logic [ROUND_W-1:0] dr_left_ff, dr_left_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [REG_W-1:0]   rsp_lo_ff, rsp_lo_in;
   logic [REG_W-1:0]   rsp_hi_ff, rsp_hi_in;
   logic [COUNT_W-1:0] rsp_bytes_ff, rsp_bytes_in;

   word_type init_w [16];
   word_type feed_w [16];
   word_type lane_na [4];
   word_type lane_nb [4];
   word_type lane_nc [4];
   word_type lane_nd [4];

   logic               req_xfer;
   logic               rsp_xfer;
   logic [COUNT_W-1:0] req_count;
   logic [COUNT_W-1:0] req_count_sat;
   logic [ROUND_W:0]   round_plus_one;
   logic [ROUND_W-1:0] dr_load;
   logic               out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_count     = req_tdata[COUNT_W-1:0];
   assign req_count_sat = (req_count > MAX_BYTES) ? MAX_BYTES : req_count;

   // odd round counts round up to the next double round
   assign round_plus_one = {1'b0, round_count_ff} + {{ROUND_W{1'b0}}, 1'b1};
   assign dr_load        = round_plus_one[ROUND_W:1];

   // block input: constants, key, zero counter, nonce
   for (genvar i = 0; i < 4; i++) begin : g_init_const
      assign init_w[i] = EXPAND_WORDS[i];
   end
   for (genvar i = 0; i < 8; i++) begin : g_init_key
      assign init_w[4+i] = key_ff[i];
   end
   assign init_w[12] = '0;
   assign init_w[13] = '0;
   assign init_w[14] = nonce_ff[0];
   assign init_w[15] = nonce_ff[1];

   // feed-forward add
   for (genvar i = 0; i < 16; i++) begin : g_feed
      assign feed_w[i] = w_ff[i] + init_w[i];
   end

   // four quarter-round lanes; on a diagonal round the b, c and d rows are
   // taken one, two and three columns further on
   for (genvar l = 0; l < 4; l++) begin : g_lane
      word_type a, b, c, d;
      word_type sum, mixed, rotated;

      assign a = w_ff[l];
      assign b = diag_ff ? w_ff[4+((l+1)%4)]  : w_ff[4+l];
      assign c = diag_ff ? w_ff[8+((l+2)%4)]  : w_ff[8+l];
      assign d = diag_ff ? w_ff[12+((l+3)%4)] : w_ff[12+l];

      // even steps: a += b, d ^= a; odd steps: c += d, b ^= c
      assign sum   = step_ff[0] ? (c + d) : (a + b);
      assign mixed = (step_ff[0] ? b : d) ^ sum;

      always_comb begin
         unique case (step_ff)
            2'd0: rotated = {mixed[15:0], mixed[31:16]};
            2'd1: rotated = {mixed[19:0], mixed[31:20]};
            2'd2: rotated = {mixed[23:0], mixed[31:24]};
            2'd3: rotated = {mixed[24:0], mixed[31:25]};
            default: rotated = mixed;
         endcase
      end

      assign lane_na[l] = step_ff[0] ? a : sum;
      assign lane_nd[l] = step_ff[0] ? d : rotated;
      assign lane_nc[l] = step_ff[0] ? sum : c;
      assign lane_nb[l] = step_ff[0] ? rotated : b;
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      diag_in      = diag_ff;
      dr_left_in   = dr_left_ff;
      bytes_in     = bytes_ff;
      w_in         = w_ff;
      key_in       = key_ff;
      nonce_in     = nonce_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_lo_in    = rsp_lo_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_bytes_in = rsp_bytes_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_tuser == REQ_RESEED) begin
               for (int i = 0; i < 4; i++) begin
                  key_in[2*i]   = seed_key_ff[i][WORD_W-1:0];
                  key_in[2*i+1] = seed_key_ff[i][REG_W-1:WORD_W];
               end
               nonce_in[0] = seed_nonce_ff[WORD_W-1:0];
               nonce_in[1] = seed_nonce_ff[REG_W-1:WORD_W];
            end else if (req_xfer && req_count != '0) begin
               w_in       = init_w;
               step_in    = 2'd0;
               diag_in    = 1'b0;
               dr_left_in = dr_load;
               bytes_in   = req_count_sat;
               state_in   = (dr_load == '0) ? ST_FEED : ST_RUN;
            end
         end
         ST_RUN: begin
            for (int j = 0; j < 4; j++) begin
               w_in[j]    = lane_na[j];
               w_in[4+j]  = diag_ff ? lane_nb[(j+3)%4] : lane_nb[j];
               w_in[8+j]  = diag_ff ? lane_nc[(j+2)%4] : lane_nc[j];
               w_in[12+j] = diag_ff ? lane_nd[(j+1)%4] : lane_nd[j];
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               diag_in = !diag_ff;
               if (diag_ff) begin
                  dr_left_in = dr_left_ff - {{(ROUND_W-1){1'b0}}, 1'b1};
                  if (dr_left_ff == {{(ROUND_W-1){1'b0}}, 1'b1}) begin
                     state_in = ST_FEED;
                  end
               end
            end
         end
         ST_FEED: begin
            // hold the finished block until the output register is free
            if (out_free) begin
               for (int i = 0; i < 8; i++) begin
                  key_in[i] = feed_w[i];
               end
               nonce_in[0]  = feed_w[8];
               nonce_in[1]  = feed_w[9];
               rsp_lo_in    = {feed_w[11], feed_w[10]};
               rsp_hi_in    = {feed_w[13], feed_w[12]};
               rsp_bytes_in = bytes_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and key state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            key_ff[i] <= '0;
         end
         nonce_ff[0]  <= '0;
         nonce_ff[1]  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff       <= key_in;
         nonce_ff     <= nonce_in;
      end
   end

   // working block and payload
   always_ff @(posedge clock) begin
      w_ff         <= w_in;
      step_ff      <= step_in;
      diag_ff      <= diag_in;
      dr_left_ff   <= dr_left_in;
      bytes_ff     <= bytes_in;
      rsp_lo_ff    <= rsp_lo_in;
      rsp_hi_ff    <= rsp_hi_in;
      rsp_bytes_ff <= rsp_bytes_in;
   end

   // configuration writes; indexes past the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= ROUND_COUNT_RESET;
         for (int i = 0; i < 4; i++) begin
            seed_key_ff[i] <= '0;
         end
         seed_nonce_ff  <= '0;
      end else if (csr_wen) begin
         if (csr_index == REG_ROUND_COUNT) begin
            round_count_ff <= csr_wdata[ROUND_W-1:0];
         end
         if (csr_index == REG_SEED_KEY_A) begin
            seed_key_ff[0] <= csr_wdata;
         end
         if (csr_index == REG_SEED_KEY_B) begin
            seed_key_ff[1] <= csr_wdata;
         end
         if (csr_index == REG_SEED_KEY_C) begin
            seed_key_ff[2] <= csr_wdata;
         end
         if (csr_index == REG_SEED_KEY_D) begin
            seed_key_ff[3] <= csr_wdata;
         end
         if (csr_index == REG_SEED_NONCE) begin
            seed_nonce_ff <= csr_wdata;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*REG_W-COUNT_W){1'b0}}, rsp_bytes_ff, rsp_hi_ff, rsp_lo_ff};

endmodule

### design/ckerng_checker.sv
module ckerng_checker
   import ckerng_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a generate with bytes wanted keeps the request side busy
   a_gen_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_GENERATE
      && req_tdata[COUNT_W-1:0] != '0 |=> !req_tready)
      else $error("request taken during a block run");

   // a reseed finishes in its own cycle
   a_reseed_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_RESEED |=> req_tready)
      else $error("reseed held the request side");

   // byte count of a result is saturated and never zero
   a_rsp_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2*REG_W +: COUNT_W] != '0
      && rsp_tdata[2*REG_W +: COUNT_W] <= MAX_BYTES
      && rsp_tdata[RSP_DATA_W-1:2*REG_W+COUNT_W] == '0)
      else $error("bad result byte count");

   // reset empties the output and frees the request side
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state after reset");

endmodule

bind chacha_key_erasure_rng ckerng_checker u_ckerng_checker (.*);

### tb/ckerng_checker.sv
`timescale 1ns / 1ps
module ckerng_tb_checker
   import ckerng_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [4:0] byte_count
   input  logic                   req_tuser,   // [0] req_type
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,   // [63:0] random_lo, [127:64] random_hi,
                                               // [132:128] valid_bytes
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_wdata,
   output int                     mismatch_count,
   output int                     draws_waiting
);

   typedef struct packed {
      logic [REG_W-1:0]   random_lo;
      logic [REG_W-1:0]   random_hi;
      logic [COUNT_W-1:0] valid_bytes;
   } rng_draw_type;

   rng_draw_type pending_draws [$];

   logic [ROUND_W-1:0]     round_setting;
   logic [REG_W-1:0]       seed_key [4];
   logic [REG_W-1:0]       seed_nonce;
   logic [8*WORD_W-1:0]    key_state;     // key word 0 lowest
   logic [2*WORD_W-1:0]    nonce_state;   // state word 14 lowest

   function automatic word_type rotl(input word_type v, input int s);
      return (v << s) | (v >> (WORD_W - s));
   endfunction

   // returns {d, c, b, a}
   function automatic logic [4*WORD_W-1:0] quarter_mix(input word_type a, input word_type b,
                                                       input word_type c, input word_type d);
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      return {d, c, b, a};
   endfunction

   function automatic logic [16*WORD_W-1:0] apply_quarter(input logic [16*WORD_W-1:0] s,
                                                          input int a, input int b,
                                                          input int c, input int d);
      logic [4*WORD_W-1:0] q;
      q = quarter_mix(s[a*WORD_W +: WORD_W], s[b*WORD_W +: WORD_W],
                      s[c*WORD_W +: WORD_W], s[d*WORD_W +: WORD_W]);
      s[a*WORD_W +: WORD_W] = q[0 +: WORD_W];
      s[b*WORD_W +: WORD_W] = q[WORD_W +: WORD_W];
      s[c*WORD_W +: WORD_W] = q[2*WORD_W +: WORD_W];
      s[d*WORD_W +: WORD_W] = q[3*WORD_W +: WORD_W];
      return s;
   endfunction

   function automatic logic [16*WORD_W-1:0] chacha_block(input logic [ROUND_W-1:0] rounds,
                                                         input logic [8*WORD_W-1:0] key,
                                                         input logic [2*WORD_W-1:0] nonce);
      logic [16*WORD_W-1:0] init;
      logic [16*WORD_W-1:0] w;
      logic [16*WORD_W-1:0] sum;
      int doubles;
      int i;
      init = {nonce, {2*WORD_W{1'b0}}, key,
              EXPAND_WORDS[3], EXPAND_WORDS[2], EXPAND_WORDS[1], EXPAND_WORDS[0]};
      w = init;
      // odd round counts round up to the next double round
      doubles = (int'(rounds) + 1) / 2;
      for (i = 0; i < doubles; i++) begin
         w = apply_quarter(w, 0, 4, 8, 12);
         w = apply_quarter(w, 1, 5, 9, 13);
         w = apply_quarter(w, 2, 6, 10, 14);
         w = apply_quarter(w, 3, 7, 11, 15);
         w = apply_quarter(w, 0, 5, 10, 15);
         w = apply_quarter(w, 1, 6, 11, 12);
         w = apply_quarter(w, 2, 7, 8, 13);
         w = apply_quarter(w, 3, 4, 9, 14);
      end
      for (i = 0; i < 16; i++) begin
         sum[i*WORD_W +: WORD_W] = w[i*WORD_W +: WORD_W] + init[i*WORD_W +: WORD_W];
      end
      return sum;
   endfunction

   always @(posedge clock) begin
      logic [16*WORD_W-1:0] blk;
      logic [COUNT_W-1:0]   nbytes;
      rng_draw_type         want;
      rng_draw_type         got;
      if (reset) begin
         round_setting = ROUND_COUNT_RESET;
         for (int i = 0; i < 4; i++) seed_key[i] = '0;
         seed_nonce    = '0;
         key_state     = '0;
         nonce_state   = '0;
         pending_draws.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_ROUND_COUNT: round_setting = csr_wdata[ROUND_W-1:0];
               REG_SEED_KEY_A:  seed_key[0] = csr_wdata;
               REG_SEED_KEY_B:  seed_key[1] = csr_wdata;
               REG_SEED_KEY_C:  seed_key[2] = csr_wdata;
               REG_SEED_KEY_D:  seed_key[3] = csr_wdata;
               REG_SEED_NONCE:  seed_nonce = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.random_lo   = rsp_tdata[63:0];
            got.random_hi   = rsp_tdata[127:64];
            got.valid_bytes = rsp_tdata[132:128];
            if (pending_draws.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("ckerng_checker: result with nothing pending: lo %h hi %h bytes %0d",
                           got.random_lo, got.random_hi, got.valid_bytes);
            end else begin
               want = pending_draws.pop_front();
               if (got.random_lo !== want.random_lo || got.random_hi !== want.random_hi ||
                   got.valid_bytes !== want.valid_bytes) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display("ckerng_checker: mismatch, expected lo %h hi %h bytes %0d",
                              want.random_lo, want.random_hi, want.valid_bytes);
                     $display("ckerng_checker:           actual   lo %h hi %h bytes %0d",
                              got.random_lo, got.random_hi, got.valid_bytes);
                  end
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == REQ_RESEED) begin
               key_state   = {seed_key[3], seed_key[2], seed_key[1], seed_key[0]};
               nonce_state = seed_nonce;
            end else if (req_tdata[COUNT_W-1:0] != '0) begin
               nbytes = (req_tdata[COUNT_W-1:0] > MAX_BYTES) ? MAX_BYTES
                                                             : req_tdata[COUNT_W-1:0];
               blk = chacha_block(round_setting, key_state, nonce_state);
               want.random_lo   = blk[10*WORD_W +: 2*WORD_W];
               want.random_hi   = blk[12*WORD_W +: 2*WORD_W];
               want.valid_bytes = nbytes;
               pending_draws.push_back(want);
               // key erasure: words 0..9 of the block become key and nonce
               key_state   = blk[0 +: 8*WORD_W];
               nonce_state = blk[8*WORD_W +: 2*WORD_W];
            end
         end
      end
      draws_waiting <= pending_draws.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import ckerng_pkg::*;

   localparam int HOLD_OFF_CYCLES = 600;      // long receiver stall to back up the block
   localparam int DRAIN_CYCLES    = 160;      // beyond the slowest block (31 rounds)
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 68;

   // indexes past the register list, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = REQ_RESEED;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [REG_W-1:0]       csr_wdata  = '0;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire [RSP_DATA_W-1:0]   rsp_tdata;

   int mismatch_count;
   int draws_waiting;
   int cycle_count    = 0;
   logic hold_off_req = 1'b0;   // asks the receiver for its one long stall
   bit quiet_sender   = 1'b0;   // no gaps between requests in this phase

   chacha_key_erasure_rng uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ckerng_tb_checker u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .draws_waiting  (draws_waiting)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: a hung block ends the run here
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   // idle lengths: mostly none or short, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 98) return $urandom_range(5, 24);
      return $urandom_range(40, 120);
   endfunction

   function automatic logic [REG_W-1:0] random_reg();
      return {$urandom, $urandom};
   endfunction

   // seeds: all zero and all ones now and then, random otherwise
   function automatic logic [REG_W-1:0] pick_seed();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return random_reg();
   endfunction

   // round counts: the extremes often, small ones otherwise to keep the run short
   function automatic logic [ROUND_W-1:0] pick_rounds();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return ROUND_COUNT_RESET;
      if (r == 3) return ROUND_W'(2);
      return ROUND_W'($urandom_range(0, 12));
   endfunction

   // offer one request and hold it until the transfer; valid stays high afterwards
   // so that a back-to-back request needs no second assignment in the same step
   task automatic push_request(input logic kind, input logic [COUNT_W-1:0] count);
      int gap;
      gap = quiet_sender ? 0 : idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_DATA_W'(count);
      do @(posedge clock); while (!req_tready);
   endtask

   // csr writes happen back to back; the caller lowers the enable afterwards
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic reconfigure(input logic [ROUND_W-1:0] rounds,
                              input logic [REG_W-1:0] key_a, input logic [REG_W-1:0] key_b,
                              input logic [REG_W-1:0] key_c, input logic [REG_W-1:0] key_d,
                              input logic [REG_W-1:0] nonce);
      logic [REG_W-1:0] junk;
      junk = random_reg();
      // upper bits of the round register are don't-care, so keep them noisy
      write_reg(REG_ROUND_COUNT, {junk[REG_W-1:ROUND_W], rounds});
      write_reg(REG_SEED_KEY_A, key_a);
      write_reg(REG_SEED_KEY_B, key_b);
      write_reg(REG_SEED_KEY_C, key_c);
      write_reg(REG_SEED_KEY_D, key_d);
      write_reg(REG_SEED_NONCE, nonce);
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, random_reg());
      csr_wen <= 1'b0;
   endtask

   // idle point: every predicted result has come out and a dropped request
   // (zero byte count) has had time to leave the block
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (draws_waiting != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random ready pattern, plus one long hold-off on request
   initial begin : rsp_sink
      bit held;
      int stall;
      int run;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         stall = idle_length();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
      end
   end

   initial begin : stimulus
      int phase;
      int n;
      int r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 20 rounds, all-zero key and nonce
      push_request(REQ_GENERATE, MAX_BYTES);
      push_request(REQ_GENERATE, COUNT_W'(1));
      push_request(REQ_GENERATE, COUNT_W'(0));     // zero bytes, dropped
      push_request(REQ_GENERATE, COUNT_W'(17));    // above sixteen saturates
      push_request(REQ_GENERATE, COUNT_W'(31));
      push_request(REQ_RESEED, COUNT_W'(31));      // zero seeds bring back the reset key
      push_request(REQ_GENERATE, MAX_BYTES);
      settle();

      // all-ones seeds
      reconfigure(ROUND_COUNT_RESET, '1, '1, '1, '1, '1);
      push_request(REQ_RESEED, COUNT_W'(0));
      push_request(REQ_GENERATE, COUNT_W'(8));
      settle();

      // no rounds at all: output is the doubled input
      reconfigure('0, random_reg(), random_reg(), random_reg(), random_reg(), random_reg());
      push_request(REQ_GENERATE, COUNT_W'(5));
      push_request(REQ_GENERATE, MAX_BYTES);
      settle();

      // odd count rounds up
      reconfigure(ROUND_W'(1), random_reg(), '0, random_reg(), '0, '1);
      push_request(REQ_RESEED, COUNT_W'(16));
      push_request(REQ_GENERATE, COUNT_W'(3));
      settle();

      // largest round count, past twenty
      reconfigure('1, '0, '0, '0, '0, '0);
      push_request(REQ_GENERATE, MAX_BYTES);
      push_request(REQ_GENERATE, COUNT_W'(2));
      settle();

      reconfigure(ROUND_W'(2), random_reg(), random_reg(), random_reg(), random_reg(), '0);
      push_request(REQ_RESEED, COUNT_W'(0));
      push_request(REQ_GENERATE, MAX_BYTES);
      push_request(REQ_GENERATE, COUNT_W'(0));
      push_request(REQ_GENERATE, COUNT_W'(9));
      settle();

      reconfigure(ROUND_W'(21), '1, random_reg(), '1, random_reg(), random_reg());
      push_request(REQ_GENERATE, COUNT_W'(12));

      // random phases: each opens with a reseed, then mostly generates
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         // first phase runs full rounds so that it outlasts the start of the hold-off
         reconfigure((phase == 0) ? ROUND_COUNT_RESET : pick_rounds(),
                     pick_seed(), pick_seed(), pick_seed(), pick_seed(), pick_seed());
         quiet_sender = (phase == 0) || ($urandom_range(0, 3) == 0);
         // first phase: receiver stalls for long while requests keep coming
         if (phase == 0) hold_off_req <= 1'b1;
         push_request(REQ_RESEED, COUNT_W'($urandom_range(0, 31)));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               push_request(REQ_RESEED, COUNT_W'($urandom_range(0, 31)));
            else if (r < 85)
               push_request(REQ_GENERATE, COUNT_W'($urandom_range(1, 16)));
            else
               push_request(REQ_GENERATE, COUNT_W'($urandom_range(0, 31)));
         end
      end
      settle();

      if (mismatch_count == 0 && draws_waiting == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
